// File: design/calendar_date_offset_macros.svh
// Assertion macros for the calendar date offset block.
// Included by calendar_date_offset.sv; NO_ASSERTIONS compiles every check out.
`ifndef CALENDAR_DATE_OFFSET_MACROS_SVH
`define CALENDAR_DATE_OFFSET_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CDO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CDO_ASSERT(lbl, prop, msg)
`define CDO_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/cdo_pkg.sv
// Package for the calendar date offset block: field widths, sequencer states,
// reciprocal constants and month tables. No dependencies.
`timescale 1ns / 1ps
package cdo_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFS_W   = 23;

    // day numbers with an offset applied, signed
    localparam int DN_W     = 26;
    localparam int REM_W    = 25;
    localparam int PART_W   = 16;
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 19;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int RECIP_SH = 25;
    localparam int Q_W      = 8;
    localparam int YR_W     = 16;
    localparam int DOY_W    = 9;

    localparam logic [MUL_B_W-1:0] RECIP_100_CEIL = 19'd335545;
    localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR  = 19'd365;
    localparam logic [REM_W-1:0]   DAYS_LEAP_YEAR = 25'd366;

    localparam logic signed [OFS_W-1:0] DIST_HI = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] DIST_LO = {1'b1, {(OFS_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YQ,
        ST_YM,
        ST_YS,
        ST_OFS,
        ST_DQ,
        ST_DP,
        ST_DF,
        ST_MON,
        ST_DIST,
        ST_WB
    } t_state;

    typedef enum logic [1:0] {
        LVL_400Y,
        LVL_100Y,
        LVL_4Y,
        LVL_1Y
    } t_level;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_DIST = 1'b1
    } t_action;

    // days in each cycle of the decomposition
    function automatic logic [REM_W-1:0] div_const(input t_level lvl);
        logic [REM_W-1:0] d;
        case (lvl)
            LVL_400Y: d = 25'd146097;
            LVL_100Y: d = 25'd36524;
            LVL_4Y:   d = 25'd1461;
            LVL_1Y:   d = 25'd365;
            default:  d = 25'd365;
        endcase
        return d;
    endfunction

    // floor(2^RECIP_SH / div_const); the estimate is low by at most one
    function automatic logic [MUL_B_W-1:0] recip_const(input t_level lvl);
        logic [MUL_B_W-1:0] m;
        case (lvl)
            LVL_400Y: m = 19'd229;
            LVL_100Y: m = 19'd918;
            LVL_4Y:   m = 19'd22966;
            LVL_1Y:   m = 19'd91929;
            default:  m = 19'd91929;
        endcase
        return m;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the year before the first of month m
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m,
                                                           input logic leap);
        logic [DOY_W-1:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + ((leap && m > 4'd2 && m <= 4'd12) ? 9'd1 : 9'd0);
    endfunction

endpackage

// File: design/calendar_date_offset.sv
// Gregorian date arithmetic: add a day offset to a date, or day distance A to B.
// Depends on cdo_pkg and calendar_date_offset_macros.svh.
// Add: date A to day number (YQ, YM, YS), offset and range check (OFS), then DQ, DP,
// DF per level and MON give the date; bad A or range skips to WB. One request at a time.
// Distance: YQ, YM, YS for A, then B, then DIST. The 25x19 multiplier is shared.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
`timescale 1ns / 1ps
`include "calendar_date_offset_macros.svh"
module calendar_date_offset #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic        [cdo_pkg::YEAR_W-1:0]   i_year_a,
    input  logic        [cdo_pkg::MONTH_W-1:0]  i_month_a,
    input  logic        [cdo_pkg::DAY_W-1:0]    i_day_a,
    input  logic        [cdo_pkg::YEAR_W-1:0]   i_year_b,
    input  logic        [cdo_pkg::MONTH_W-1:0]  i_month_b,
    input  logic        [cdo_pkg::DAY_W-1:0]    i_day_b,
    input  logic signed [cdo_pkg::OFS_W-1:0]    i_offset_days,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [cdo_pkg::YEAR_W-1:0]   o_out_year,
    output logic        [cdo_pkg::MONTH_W-1:0]  o_out_month,
    output logic        [cdo_pkg::DAY_W-1:0]    o_out_day,
    output logic signed [cdo_pkg::OFS_W-1:0]    o_day_distance,
    output logic                                o_in_range
);
    import cdo_pkg::*;

    // Day number of 1/1/(MAX_YEAR+1): first day past the supported range.
    localparam int unsigned LIM_DAYS = MAX_YEAR * 365 + MAX_YEAR / 4
                                       - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam logic [REM_W-1:0] LIM_DN = REM_W'(LIM_DAYS);

    // Sequencer and captured request
    t_state                     r_state, n_state;
    t_action                    r_act, n_act;
    logic                       r_side, n_side;      // 0: date A, 1: date B
    logic        [YEAR_W-1:0]   r_ya, n_ya, r_yb, n_yb;
    logic        [MONTH_W-1:0]  r_ma, n_ma, r_mb, n_mb;
    logic        [DAY_W-1:0]    r_da, n_da, r_db, n_db;
    logic signed [OFS_W-1:0]    r_off, n_off;

    // Shared multiplier output and working values
    logic        [MUL_P_W-1:0]  r_prod, n_prod;
    logic        [PART_W-1:0]   r_part, n_part;
    logic                       r_dvalid, n_dvalid;
    logic                       r_va, n_va;
    logic signed [DN_W-1:0]     r_dn_a, n_dn_a, r_dn_b, n_dn_b;
    logic        [REM_W-1:0]    r_rem, n_rem;
    logic        [Q_W-1:0]      r_q, n_q;
    t_level                     r_lvl, n_lvl;
    logic        [YR_W-1:0]     r_yacc, n_yacc;
    logic        [2:0]          r_q100, n_q100;
    logic        [4:0]          r_q4, n_q4;
    logic        [2:0]          r_q1, n_q1;

    // Result staging and output register
    logic        [YEAR_W-1:0]   r_ry, n_ry;
    logic        [MONTH_W-1:0]  r_rm, n_rm;
    logic        [DAY_W-1:0]    r_rd, n_rd;
    logic signed [OFS_W-1:0]    r_dist, n_dist;
    logic                       r_ok, n_ok;
    logic                       r_o_valid, n_o_valid;
    logic        [YEAR_W-1:0]   r_o_year, n_o_year;
    logic        [MONTH_W-1:0]  r_o_month, n_o_month;
    logic        [DAY_W-1:0]    r_o_day, n_o_day;
    logic signed [OFS_W-1:0]    r_o_dist, n_o_dist;
    logic                       r_o_range, n_o_range;

    // Combinational helpers
    logic        [YEAR_W-1:0]   cur_y;
    logic        [MONTH_W-1:0]  cur_m;
    logic        [DAY_W-1:0]    cur_d;
    logic        [MUL_A_W-1:0]  mul_a;
    logic        [MUL_B_W-1:0]  mul_b;
    logic        [MUL_P_W-1:0]  mul_p;
    logic        [Q_W-1:0]      q_y;
    logic        [YEAR_W-1:0]   c100;
    logic                       cent;
    logic                       leap_y;
    logic        [YEAR_W-1:0]   p_y;
    logic        [Q_W-1:0]      qp;
    logic        [PART_W-1:0]   part;
    logic                       date_ok;
    logic signed [DN_W-1:0]     dn_sum;
    logic signed [DN_W-1:0]     ofs_sum;
    logic                       ofs_ok;
    logic        [Q_W-1:0]      q_est;
    logic        [REM_W-1:0]    dv;
    logic        [REM_W-1:0]    r0;
    logic        [Q_W-1:0]      qf;
    logic        [REM_W-1:0]    rf;
    logic        [YR_W-1:0]     yacc_nx;
    logic                       leap_r;
    logic        [YR_W-1:0]     yy;
    logic        [DOY_W-1:0]    doy;
    logic        [MONTH_W-1:0]  mm;
    logic        [DAY_W-1:0]    dd;
    logic signed [DN_W-1:0]     diff;
    logic signed [OFS_W-1:0]    dist_sat;
    logic                       out_free;

    // ------------------------------------------------------------------
    // Shared multiplier: each state picks its operands. Every product is
    // registered before anything downstream uses it.
    // ------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_YQ: begin
                // year / 100 through a rounded-up reciprocal, exact for 14-bit years
                mul_a = MUL_A_W'(cur_y);
                mul_b = RECIP_100_CEIL;
            end
            ST_YM: begin
                mul_a = MUL_A_W'(p_y);
                mul_b = DAYS_PER_YEAR;
            end
            ST_DQ: begin
                mul_a = r_rem;
                mul_b = recip_const(r_lvl);
            end
            ST_DP: begin
                mul_a = MUL_A_W'(q_est);
                mul_b = MUL_B_W'(div_const(r_lvl));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // ------------------------------------------------------------------
    // Arithmetic around the multiplier
    // ------------------------------------------------------------------
    always_comb begin
        cur_y = r_side ? r_yb : r_ya;
        cur_m = r_side ? r_mb : r_ma;
        cur_d = r_side ? r_db : r_da;

        // Forward: days before year y = p*365 + p/4 - p/100 + p/400, p = y - 1.
        // p/100 follows from y/100 minus one when y is a century year.
        q_y    = r_prod[RECIP_SH +: Q_W];
        c100   = (YEAR_W'(q_y) << 6) + (YEAR_W'(q_y) << 5) + (YEAR_W'(q_y) << 2);
        cent   = (c100 == cur_y);
        leap_y = (cur_y[1:0] == 2'd0) && (!cent || q_y[1:0] == 2'd0);
        p_y    = cur_y - YEAR_W'(1);
        qp     = q_y - Q_W'(cent);
        part   = PART_W'(p_y >> 2) - PART_W'(qp) + PART_W'(qp >> 2)
                 + PART_W'(days_before_month(cur_m, leap_y)) + PART_W'(cur_d) - PART_W'(1);
        date_ok = (cur_y != '0) && (32'(cur_y) <= MAX_YEAR)
                  && (cur_m >= 4'd1) && (cur_m <= 4'd12)
                  && (cur_d != '0) && (cur_d <= month_days(cur_m, leap_y));
        dn_sum = DN_W'(r_prod[REM_W-1:0]) + DN_W'(r_part);

        // Offset applied to date A and range check against the last day
        ofs_sum = r_dn_a + DN_W'(r_off);
        ofs_ok  = !ofs_sum[DN_W-1] && (ofs_sum[REM_W-1:0] < LIM_DN);

        // Reverse: one level of the 400/100/4/1 year decomposition.
        // Estimate is low by at most one; a compare and subtract fixes it.
        q_est = r_prod[RECIP_SH +: Q_W];
        dv    = div_const(r_lvl);
        r0    = r_rem - r_prod[REM_W-1:0];
        if (r0 >= dv) begin
            qf = r_q + Q_W'(1);
            rf = r0 - dv;
        end else begin
            qf = r_q;
            rf = r0;
        end
        // Last day of a 400-year cycle, or of a leap year: hold the quotient at 3
        if ((r_lvl == LVL_100Y || r_lvl == LVL_1Y) && qf == Q_W'(4)) begin
            qf = Q_W'(3);
            rf = dv;
        end

        // Years before the result, Horner form: ((q400*4 + q100)*25 + q4)*4 + q1
        case (r_lvl)
            LVL_400Y: yacc_nx = YR_W'(qf);
            LVL_100Y: yacc_nx = (r_yacc << 2) + YR_W'(qf);
            LVL_4Y:   yacc_nx = (r_yacc << 4) + (r_yacc << 3) + r_yacc + YR_W'(qf);
            LVL_1Y:   yacc_nx = (r_yacc << 2) + YR_W'(qf);
            default:  yacc_nx = r_yacc;
        endcase

        // Month search over the day of year; leap year read off the quotients
        leap_r = (r_q1 == 3'd3) && (r_q4 != 5'd24 || r_q100 == 3'd3);
        yy     = r_yacc + YR_W'(1);
        doy    = r_rem[DOY_W-1:0];
        mm     = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (doy >= days_before_month(MONTH_W'(k), leap_r)) begin
                mm = MONTH_W'(k);
            end
        end
        dd = DAY_W'(doy - days_before_month(mm, leap_r) + DOY_W'(1));

        // Distance with saturation to the output width
        diff = r_dn_b - r_dn_a;
        if (diff > DN_W'(DIST_HI)) begin
            dist_sat = DIST_HI;
        end else if (diff < DN_W'(DIST_LO)) begin
            dist_sat = DIST_LO;
        end else begin
            dist_sat = diff[OFS_W-1:0];
        end

        out_free = !r_o_valid || i_ready;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_YQ;
                end
            end
            ST_YQ: n_state = ST_YM;
            ST_YM: n_state = ST_YS;
            ST_YS: begin
                if (!r_side) begin
                    if (r_act == ACT_ADD) begin
                        n_state = r_dvalid ? ST_OFS : ST_WB;
                    end else begin
                        n_state = ST_YQ;
                    end
                end else begin
                    n_state = (r_va && r_dvalid) ? ST_DIST : ST_WB;
                end
            end
            ST_OFS:  n_state = ofs_ok ? ST_DQ : ST_WB;
            ST_DQ:   n_state = ST_DP;
            ST_DP:   n_state = ST_DF;
            ST_DF:   n_state = (r_lvl == LVL_1Y) ? ST_MON : ST_DQ;
            ST_MON:  n_state = ST_WB;
            ST_DIST: n_state = ST_WB;
            ST_WB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_act     = r_act;
        n_side    = r_side;
        n_ya      = r_ya;
        n_ma      = r_ma;
        n_da      = r_da;
        n_yb      = r_yb;
        n_mb      = r_mb;
        n_db      = r_db;
        n_off     = r_off;
        n_prod    = r_prod;
        n_part    = r_part;
        n_dvalid  = r_dvalid;
        n_va      = r_va;
        n_dn_a    = r_dn_a;
        n_dn_b    = r_dn_b;
        n_rem     = r_rem;
        n_q       = r_q;
        n_lvl     = r_lvl;
        n_yacc    = r_yacc;
        n_q100    = r_q100;
        n_q4      = r_q4;
        n_q1      = r_q1;
        n_ry      = r_ry;
        n_rm      = r_rm;
        n_rd      = r_rd;
        n_dist    = r_dist;
        n_ok      = r_ok;
        n_o_valid = r_o_valid && !i_ready;
        n_o_year  = r_o_year;
        n_o_month = r_o_month;
        n_o_day   = r_o_day;
        n_o_dist  = r_o_dist;
        n_o_range = r_o_range;

        case (r_state)
            ST_IDLE: begin
                // Capture the request and clear the result to the not-valid form
                if (i_valid) begin
                    n_act  = t_action'(i_action);
                    n_side = 1'b0;
                    n_ya   = i_year_a;
                    n_ma   = i_month_a;
                    n_da   = i_day_a;
                    n_yb   = i_year_b;
                    n_mb   = i_month_b;
                    n_db   = i_day_b;
                    n_off  = i_offset_days;
                    n_ry   = '0;
                    n_rm   = '0;
                    n_rd   = '0;
                    n_dist = '0;
                    n_ok   = 1'b0;
                end
            end
            ST_YQ: begin
                n_prod = mul_p;
            end
            ST_YM: begin
                n_prod   = mul_p;
                n_part   = part;
                n_dvalid = date_ok;
            end
            ST_YS: begin
                if (!r_side) begin
                    n_dn_a = dn_sum;
                    n_va   = r_dvalid;
                    n_side = 1'b1;
                end else begin
                    n_dn_b = dn_sum;
                end
            end
            ST_OFS: begin
                n_rem  = ofs_sum[REM_W-1:0];
                n_lvl  = LVL_400Y;
                n_yacc = '0;
            end
            ST_DQ: begin
                n_prod = mul_p;
            end
            ST_DP: begin
                n_q    = q_est;
                n_prod = mul_p;
            end
            ST_DF: begin
                n_rem  = rf;
                n_yacc = yacc_nx;
                case (r_lvl)
                    LVL_100Y: n_q100 = qf[2:0];
                    LVL_4Y:   n_q4   = qf[4:0];
                    LVL_1Y:   n_q1   = qf[2:0];
                    default:  n_q100 = r_q100;
                endcase
                n_lvl = t_level'(r_lvl + 2'd1);
            end
            ST_MON: begin
                n_ry = yy[YEAR_W-1:0];
                n_rm = mm;
                n_rd = dd;
                n_ok = 1'b1;
            end
            ST_DIST: begin
                n_dist = dist_sat;
                n_ok   = 1'b1;
            end
            ST_WB: begin
                // Move the staged result into the output register once it is free
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_year  = r_ry;
                    n_o_month = r_rm;
                    n_o_day   = r_rd;
                    n_o_dist  = r_dist;
                    n_o_range = r_ok;
                end
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers: control state is reset, payload is not
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_side    <= n_side;
        r_ya      <= n_ya;
        r_ma      <= n_ma;
        r_da      <= n_da;
        r_yb      <= n_yb;
        r_mb      <= n_mb;
        r_db      <= n_db;
        r_off     <= n_off;
        r_prod    <= n_prod;
        r_part    <= n_part;
        r_dvalid  <= n_dvalid;
        r_va      <= n_va;
        r_dn_a    <= n_dn_a;
        r_dn_b    <= n_dn_b;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_lvl     <= n_lvl;
        r_yacc    <= n_yacc;
        r_q100    <= n_q100;
        r_q4      <= n_q4;
        r_q1      <= n_q1;
        r_ry      <= n_ry;
        r_rm      <= n_rm;
        r_rd      <= n_rd;
        r_dist    <= n_dist;
        r_ok      <= n_ok;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_day   <= n_o_day;
        r_o_dist  <= n_o_dist;
        r_o_range <= n_o_range;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_valid        = r_o_valid;
        o_out_year     = r_o_year;
        o_out_month    = r_o_month;
        o_out_day      = r_o_day;
        o_day_distance = r_o_dist;
        o_in_range     = r_o_range;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CDO_ASSERT_RST(a_reset_idle, !i_rst_n |=> (!o_valid && o_ready), "reset did not idle block")
    `CDO_ASSERT(a_invalid_zero, (o_valid && !o_in_range) |-> (o_out_year == '0 && o_out_month == '0 && o_out_day == '0 && o_day_distance == '0), "out-of-range result not zeroed")
    `CDO_ASSERT(a_date_form, (o_valid && o_out_month != '0) |-> (o_in_range && o_out_month <= 4'd12 && o_out_day != '0 && o_day_distance == '0), "malformed date result")
    `CDO_ASSERT(a_doy_bound, (r_state == ST_MON) |-> (r_rem < DAYS_LEAP_YEAR), "day of year past year end")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for calendar_date_offset: date plus day offset, and day distance.
// Needs cdo_pkg and the calendar_date_offset RTL; a scoreboard class predicts every transfer.
`timescale 1ns / 1ps
module tb_top;
    import cdo_pkg::*;

    localparam int MAX_YEAR    = 9999;
    localparam int DAYS_400Y   = 146097;
    localparam int DAYS_100Y   = 36524;
    localparam int DAYS_4Y     = 1461;
    localparam int DIST_CAP_HI = 4194303;
    localparam int DIST_CAP_LO = -4194304;
    localparam int RANDOM_REQS = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        t_action                    action;
        logic [YEAR_W-1:0]          year_a;
        logic [MONTH_W-1:0]         month_a;
        logic [DAY_W-1:0]           day_a;
        logic [YEAR_W-1:0]          year_b;
        logic [MONTH_W-1:0]         month_b;
        logic [DAY_W-1:0]           day_b;
        logic signed [OFS_W-1:0]    offset_days;
    } t_date_req;

    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic signed [OFS_W-1:0]    distance;
        logic                       in_range;
    } t_date_result;

    // Holds the expected results in request order and grades each result transfer.
    class date_scoreboard;
        t_date_result expected_q[$];
        int errors;
        int results;
        int rejected;

        function bit is_leap(int y);
            return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        endfunction

        function int month_len(int y, int m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return is_leap(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function bit date_ok(int y, int m, int d);
            return y >= 1 && y <= MAX_YEAR && m >= 1 && m <= 12 &&
                   d >= 1 && d <= month_len(y, m);
        endfunction

        // days from 1/1/1 up to 1/1 of year y
        function int days_to_year(int y);
            int p;
            p = y - 1;
            return p * 365 + p / 4 - p / 100 + p / 400;
        endfunction

        function int serial_day(int y, int m, int d);
            int n;
            n = days_to_year(y);
            for (int i = 1; i < m; i++)
                n += month_len(y, i);
            return n + d - 1;
        endfunction

        // peel off 400, 100, 4 and 1 year cycles, then walk the months
        function void split_serial(int n, output int y, output int m, output int d);
            int q400, q100, q4, q1, r;
            q400 = n / DAYS_400Y;
            r    = n % DAYS_400Y;
            q100 = r / DAYS_100Y;
            if (q100 > 3)
                q100 = 3;
            r  -= q100 * DAYS_100Y;
            q4  = r / DAYS_4Y;
            r  -= q4 * DAYS_4Y;
            q1  = r / 365;
            if (q1 > 3)
                q1 = 3;
            r -= q1 * 365;
            y  = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
            m  = 1;
            while (m < 12 && r >= month_len(y, m)) begin
                r -= month_len(y, m);
                m++;
            end
            d = r + 1;
        endfunction

        function t_date_result date_outcome(t_date_req r);
            t_date_result res;
            int n, y, m, d, gap;
            res = '0;
            if (r.action == ACT_ADD) begin
                if (date_ok(r.year_a, r.month_a, r.day_a)) begin
                    n = serial_day(r.year_a, r.month_a, r.day_a) + int'(r.offset_days);
                    if (n >= 0 && n < days_to_year(MAX_YEAR + 1)) begin
                        split_serial(n, y, m, d);
                        res.year     = YEAR_W'(y);
                        res.month    = MONTH_W'(m);
                        res.day      = DAY_W'(d);
                        res.in_range = 1'b1;
                    end
                end
            end else if (date_ok(r.year_a, r.month_a, r.day_a) &&
                         date_ok(r.year_b, r.month_b, r.day_b)) begin
                gap = serial_day(r.year_b, r.month_b, r.day_b) -
                      serial_day(r.year_a, r.month_a, r.day_a);
                if (gap > DIST_CAP_HI)
                    gap = DIST_CAP_HI;
                if (gap < DIST_CAP_LO)
                    gap = DIST_CAP_LO;
                res.distance = OFS_W'(gap);
                res.in_range = 1'b1;
            end
            return res;
        endfunction

        function void note_request(t_date_req r);
            expected_q.push_back(date_outcome(r));
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_date_result got);
            t_date_result want;
            results++;
            if (got.in_range !== 1'b1)
                rejected++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing outstanding, expected none actual %0d/%0d/%0d",
                         $time, got.year, got.month, got.day);
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_year", want.year, got.year);
            compare_field("out_month", want.month, got.month);
            compare_field("out_day", want.day, got.day);
            compare_field("day_distance", want.distance, got.distance);
            compare_field("in_range", want.in_range, got.in_range);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_ready;
    logic                       i_action      = 1'b0;
    logic [YEAR_W-1:0]          i_year_a      = '0;
    logic [MONTH_W-1:0]         i_month_a     = '0;
    logic [DAY_W-1:0]           i_day_a       = '0;
    logic [YEAR_W-1:0]          i_year_b      = '0;
    logic [MONTH_W-1:0]         i_month_b     = '0;
    logic [DAY_W-1:0]           i_day_b       = '0;
    logic signed [OFS_W-1:0]    i_offset_days = '0;
    logic                       o_valid;
    logic                       i_ready       = 1'b0;
    logic [YEAR_W-1:0]          o_out_year;
    logic [MONTH_W-1:0]         o_out_month;
    logic [DAY_W-1:0]           o_out_day;
    logic signed [OFS_W-1:0]    o_day_distance;
    logic                       o_in_range;

    date_scoreboard scoreboard = new();
    bit calm = 1'b0;      // set during the stretch where neither side stalls
    int cycles = 0;
    int adds_sent = 0;
    int dists_sent = 0;

    calendar_date_offset #(
        .MAX_YEAR(MAX_YEAR)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_year_a      (i_year_a),
        .i_month_a     (i_month_a),
        .i_day_a       (i_day_a),
        .i_year_b      (i_year_b),
        .i_month_b     (i_month_b),
        .i_day_b       (i_day_b),
        .i_offset_days (i_offset_days),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_year    (o_out_year),
        .o_out_month   (o_out_month),
        .o_out_day     (o_out_day),
        .o_day_distance(o_day_distance),
        .o_in_range    (o_in_range)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop: even the slowest legal run finishes far below this count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, scoreboard.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: grade the transfer seen at this edge, then pick ready for the next one.
    // Values read here are the ones from before the edge, so there is no race with the DUT.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                scoreboard.check_result('{year: o_out_year, month: o_out_month,
                                          day: o_out_day, distance: o_day_distance,
                                          in_range: o_in_range});
            i_ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // Drive one request and hold it until the transfer; idle first at random.
    // When no idle cycle is taken, valid stays high and only the payload moves on.
    task automatic push_request(input t_date_req r);
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= r.action;
        i_year_a      <= r.year_a;
        i_month_a     <= r.month_a;
        i_day_a       <= r.day_a;
        i_year_b      <= r.year_b;
        i_month_b     <= r.month_b;
        i_day_b       <= r.day_b;
        i_offset_days <= r.offset_days;
        do
            @(posedge i_clk);
        while (!o_ready);
        scoreboard.note_request(r);
        if (r.action == ACT_ADD)
            adds_sent++;
        else
            dists_sent++;
    endtask

    task automatic push_dated(input t_action a, input int ya, input int ma, input int da,
                              input int yb, input int mb, input int db, input int ofs);
        t_date_req r;
        r.action      = a;
        r.year_a      = YEAR_W'(ya);
        r.month_a     = MONTH_W'(ma);
        r.day_a       = DAY_W'(da);
        r.year_b      = YEAR_W'(yb);
        r.month_b     = MONTH_W'(mb);
        r.day_b       = DAY_W'(db);
        r.offset_days = OFS_W'(ofs);
        push_request(r);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge i_clk);
    endtask

    // Pick a legal date, leaning on the calendar edges and century years.
    function automatic void random_date(output logic [YEAR_W-1:0] y,
                                        output logic [MONTH_W-1:0] m,
                                        output logic [DAY_W-1:0] d);
        int yy, mm;
        case ($urandom_range(9))
            0:       yy = $urandom_range(1, 4);
            1:       yy = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
            2:       yy = 100 * $urandom_range(1, MAX_YEAR / 100);
            default: yy = $urandom_range(1, MAX_YEAR);
        endcase
        mm = $urandom_range(1, 12);
        y  = YEAR_W'(yy);
        m  = MONTH_W'(mm);
        d  = DAY_W'($urandom_range(1, scoreboard.month_len(yy, mm)));
    endfunction

    // Mostly well-formed requests with random content; the rest is raw noise
    // or a date broken in one field.
    function automatic t_date_req random_request();
        t_date_req r;
        int pick;
        int len;
        r.action      = t_action'($urandom_range(1));
        r.year_a      = YEAR_W'($urandom);
        r.month_a     = MONTH_W'($urandom);
        r.day_a       = DAY_W'($urandom);
        r.year_b      = YEAR_W'($urandom);
        r.month_b     = MONTH_W'($urandom);
        r.day_b       = DAY_W'($urandom);
        r.offset_days = OFS_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            return r;
        random_date(r.year_a, r.month_a, r.day_a);
        random_date(r.year_b, r.month_b, r.day_b);
        if (pick < 20) begin
            // break date A or date B in exactly one field
            case ($urandom_range(3))
                0: r.year_a = $urandom_range(1) ? '0 : YEAR_W'($urandom_range(MAX_YEAR + 1,
                                                                 (1 << YEAR_W) - 1));
                1: r.month_a = $urandom_range(1) ? '0 : MONTH_W'($urandom_range(13, 15));
                2: begin
                    len = scoreboard.month_len(r.year_a, r.month_a);
                    r.day_a = $urandom_range(1) ? '0 : DAY_W'($urandom_range(len + 1, 31));
                    if (len == 31)
                        r.day_a = '0;
                end
                default: begin
                    r.action = ACT_DIST;
                    r.month_b = MONTH_W'($urandom_range(13, 15));
                end
            endcase
        end
        case ($urandom_range(3))
            0: r.offset_days = OFS_W'($urandom_range(0, 800) - 400);
            1: r.offset_days = OFS_W'($urandom_range(0, 80000) - 40000);
            2: r.offset_days = OFS_W'($urandom_range(0, 7304116) - 3652058);
            default: ;  // keep the full 23-bit offset
        endcase
        return r;
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: calendar ends, offset extremes, leap days and every kind of bad date.
        push_dated(ACT_ADD, 1, 1, 1, 0, 0, 0, 0);
        push_dated(ACT_ADD, 1, 1, 1, 16383, 15, 31, -1);           // one day before the start
        push_dated(ACT_ADD, MAX_YEAR, 12, 31, 0, 0, 0, 0);
        push_dated(ACT_ADD, MAX_YEAR, 12, 31, 0, 0, 0, 1);         // one day past the end
        push_dated(ACT_ADD, 1, 1, 1, 0, 0, 0, 3652058);
        push_dated(ACT_ADD, MAX_YEAR, 12, 31, 0, 0, 0, -3652058);
        push_dated(ACT_ADD, 5000, 6, 15, 0, 0, 0, DIST_CAP_HI);
        push_dated(ACT_ADD, 5000, 6, 15, 0, 0, 0, DIST_CAP_LO);
        push_dated(ACT_ADD, 1900, 2, 28, 0, 0, 0, 1);
        push_dated(ACT_ADD, 2000, 2, 28, 0, 0, 0, 1);
        push_dated(ACT_ADD, 2024, 2, 29, 0, 0, 0, 365);
        push_dated(ACT_ADD, 2000, 12, 31, 0, 0, 0, -366);
        push_dated(ACT_ADD, 1900, 2, 29, 0, 0, 0, 0);             // not a leap year
        push_dated(ACT_ADD, 0, 1, 1, 0, 0, 0, 0);
        push_dated(ACT_ADD, 16383, 15, 31, 0, 0, 0, 0);
        push_dated(ACT_ADD, MAX_YEAR + 1, 1, 1, 0, 0, 0, -1);
        push_dated(ACT_ADD, 2023, 0, 10, 0, 0, 0, 5);
        push_dated(ACT_ADD, 2023, 13, 10, 0, 0, 0, 5);
        push_dated(ACT_ADD, 2023, 4, 0, 0, 0, 0, 5);
        push_dated(ACT_ADD, 2023, 4, 31, 0, 0, 0, 5);
        push_dated(ACT_DIST, 1, 1, 1, MAX_YEAR, 12, 31, -1);
        push_dated(ACT_DIST, MAX_YEAR, 12, 31, 1, 1, 1, DIST_CAP_HI);
        push_dated(ACT_DIST, 2000, 2, 29, 2000, 2, 29, 0);
        push_dated(ACT_DIST, 2000, 2, 29, 2100, 3, 1, 0);
        push_dated(ACT_DIST, 1999, 9, 1, 1999, 9, 31, 0);         // bad date B
        push_dated(ACT_DIST, 0, 3, 3, 16383, 15, 31, 0);          // bad date A
        drain_results();

        for (int i = 0; i < RANDOM_REQS; i++) begin
            // no stalls on either side for a long stretch in the middle
            calm = (i >= 300 && i < 420);
            if (i == 150 || $urandom_range(99) == 0)
                drain_results();
            push_request(random_request());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (scoreboard.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d add and %0d distance requests, %0d results, %0d out of range",
                 adds_sent, dists_sent, scoreboard.results, scoreboard.rejected);
        $display("with random stalls on both sides and %0d mismatches", scoreboard.errors);
        if (scoreboard.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
